>>> rtl/vrs_pkg.sv
// shared constants, codes and controller/datapath types for the versioned register store
`timescale 1ns / 1ps
package vrs_pkg;

  // sizing of the store
  localparam int INDEX_COUNT   = 64;
  localparam int HISTORY_DEPTH = 16;
  localparam int SNAP_BITS     = 16;

  // payload field widths
  localparam int OP_W      = 2;
  localparam int INDEX_W   = 6;
  localparam int VALUE_W   = 32;
  localparam int SNAP_ID_W = 16;
  localparam int STATUS_W  = 2;

  // derived widths
  localparam int IDX_AW    = (INDEX_COUNT > 1) ? $clog2(INDEX_COUNT) : 1;
  localparam int POS_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int REC_DEPTH = INDEX_COUNT * HISTORY_DEPTH;
  localparam int REC_AW    = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
  localparam int REC_W     = SNAP_BITS + VALUE_W;
  localparam int CMP_W     = (SNAP_BITS > SNAP_ID_W) ? SNAP_BITS : SNAP_ID_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_SNAP = 2'd1,
    OP_GET  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic latch_cnt;
    logic do_set;
    logic do_snap;
    logic narrow;
    logic fetch_sel;
    logic take_value;
    logic load_out;
  } vrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic lo_lt_hi;
    logic lo_nz;
  } vrs_stat_t;

endpackage

>>> rtl/vrs_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface vrs_req_if;
  import vrs_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             op;
  logic [INDEX_W-1:0]          index;
  logic signed [VALUE_W-1:0]   value;
  logic [SNAP_ID_W-1:0]        snap_id;

  modport source(output valid, op, index, value, snap_id, input ready);
  modport sink(input valid, op, index, value, snap_id, output ready);
endinterface

interface vrs_rsp_if;
  import vrs_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_W-1:0]   read_value;
  logic [SNAP_ID_W-1:0]        snap_number;
  logic [STATUS_W-1:0]         status;

  modport source(output valid, read_value, snap_number, status, input ready);
  modport sink(input valid, read_value, snap_number, status, output ready);
endinterface

>>> rtl/vrs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module vrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/vrs_dp.sv
// datapath: record and count memories, search bounds, snapshot counter, result registers
`timescale 1ns / 1ps
module vrs_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  vrs_pkg::vrs_cmd_t                  cmd,
  output vrs_pkg::vrs_stat_t                 stat,
  input  logic [vrs_pkg::OP_W-1:0]           op_in,
  input  logic [vrs_pkg::INDEX_W-1:0]        index_in,
  input  logic signed [vrs_pkg::VALUE_W-1:0] value_in,
  input  logic [vrs_pkg::SNAP_ID_W-1:0]      snap_id_in,
  output logic signed [vrs_pkg::VALUE_W-1:0] read_value,
  output logic [vrs_pkg::SNAP_ID_W-1:0]      snap_number,
  output logic [vrs_pkg::STATUS_W-1:0]       status
);
  import vrs_pkg::*;

  // latched item
  op_t                  op_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [VALUE_W-1:0]   value_q;
  logic [SNAP_ID_W-1:0] sid_q;

  // search state
  logic [POS_W-1:0]     cnt_q;
  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     hi;
  logic [POS_W-1:0]     mid;
  logic [POS_W-1:0]     pos_sel;

  // persistent state
  logic [SNAP_BITS-1:0]   cur_snap;
  logic [INDEX_COUNT-1:0] cnt_vld;

  // working result
  logic [VALUE_W-1:0]   res_value;
  logic [SNAP_ID_W-1:0] res_snap;
  logic [STATUS_W-1:0]  res_status;

  // memory ports
  logic [IDX_AW-1:0]    idx_a;
  logic [IDX_AW-1:0]    cnt_raddr;
  logic [POS_W-1:0]     cnt_rd;
  logic [POS_W-1:0]     count_now;
  logic                 cnt_we;
  logic [REC_AW-1:0]    rec_base;
  logic [REC_AW-1:0]    rec_raddr;
  logic [REC_AW-1:0]    rec_waddr;
  logic [REC_W-1:0]     rec_rd;
  logic [SNAP_BITS-1:0] rd_snap;
  logic [VALUE_W-1:0]   rd_val;
  logic                 idx_ok;
  logic                 full;
  logic                 set_ok;
  logic                 snap_le;
  logic                 at_limit;

  // addressing and decode
  assign idx_a     = IDX_AW'(idx_q);
  assign cnt_raddr = IDX_AW'(index_in);
  assign idx_ok    = 32'(idx_q) < 32'(INDEX_COUNT);
  assign count_now = cnt_vld[idx_a] ? cnt_rd : '0;
  assign full      = 32'(cnt_q) >= 32'(HISTORY_DEPTH);
  assign set_ok    = idx_ok && !full;
  assign cnt_we    = cmd.do_set && set_ok;
  assign rec_base  = REC_AW'(32'(idx_a) * HISTORY_DEPTH);
  assign mid       = lo + ((hi - lo) >> 1);
  assign pos_sel   = cmd.fetch_sel ? (lo - POS_W'(1)) : mid;
  assign rec_raddr = rec_base + REC_AW'(pos_sel);
  assign rec_waddr = rec_base + REC_AW'(cnt_q);
  assign rd_snap   = rec_rd[REC_W-1:VALUE_W];
  assign rd_val    = rec_rd[VALUE_W-1:0];
  assign snap_le   = CMP_W'(rd_snap) <= CMP_W'(sid_q);
  assign at_limit  = &cur_snap;

  // status to the controller
  assign stat.op       = op_q;
  assign stat.idx_ok   = idx_ok;
  assign stat.lo_lt_hi = lo < hi;
  assign stat.lo_nz    = lo != '0;

  // record memory: snapshot number over value
  vrs_ram #(
    .WIDTH(REC_W),
    .DEPTH(REC_DEPTH)
  ) u_rec_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(rec_waddr),
    .wdata({cur_snap, value_q}),
    .raddr(rec_raddr),
    .rdata(rec_rd)
  );

  // per-element record counts
  vrs_ram #(
    .WIDTH(POS_W),
    .DEPTH(INDEX_COUNT)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(idx_a),
    .wdata(cnt_q + POS_W'(1)),
    .raddr(cnt_raddr),
    .rdata(cnt_rd)
  );

  // count valid bits and snapshot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      cur_snap <= '0;
    end else begin
      if (cnt_we) begin
        cnt_vld[idx_a] <= 1'b1;
      end
      if (cmd.do_snap && !at_limit) begin
        cur_snap <= cur_snap + SNAP_BITS'(1);
      end
    end
  end

  // item, search bounds and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q       <= op_t'(op_in);
      idx_q      <= index_in;
      value_q    <= value_in;
      sid_q      <= snap_id_in;
      res_value  <= '0;
      res_snap   <= '0;
      res_status <= ST_OK;
    end
    if (cmd.latch_cnt) begin
      cnt_q <= count_now;
      lo    <= '0;
      hi    <= count_now;
    end
    if (cmd.do_set && !set_ok) begin
      res_status <= ST_FULL;
    end
    if (cmd.do_snap) begin
      res_snap <= SNAP_ID_W'(cur_snap);
      if (at_limit) begin
        res_status <= ST_LIMIT;
      end
    end
    if (cmd.narrow) begin
      if (snap_le) begin
        lo <= mid + POS_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.take_value) begin
      res_value <= rd_val;
    end
    if (cmd.load_out) begin
      read_value  <= res_value;
      snap_number <= res_snap;
      status      <= res_status;
    end
  end
endmodule

>>> rtl/vrs_ctrl.sv
// controller: sequences one operation at a time and owns the response valid flag
`timescale 1ns / 1ps
module vrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  vrs_pkg::vrs_stat_t stat,
  output vrs_pkg::vrs_cmd_t  cmd
);
  import vrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_EXEC,
    S_SEARCH,
    S_CMP,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // no request is taken while reset is held
  assign req_ready = (state == S_IDLE) && !rst;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.latch_in = 1'b1;
          state_next   = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.latch_cnt = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_SET: begin
            cmd.do_set = 1'b1;
            state_next = S_DONE;
          end
          OP_SNAP: begin
            cmd.do_snap = 1'b1;
            state_next  = S_DONE;
          end
          OP_GET: begin
            state_next = stat.idx_ok ? S_SEARCH : S_DONE;
          end
          OP_NONE: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SEARCH: begin
        // probe the middle record, fetch the last one not after the target, or finish when none qualifies
        priority if (stat.lo_lt_hi) begin
          state_next = S_CMP;
        end else if (stat.lo_nz) begin
          cmd.fetch_sel = 1'b1;
          state_next    = S_FETCH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        cmd.narrow = 1'b1;
        state_next = S_SEARCH;
      end
      S_FETCH: begin
        cmd.take_value = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/versioned_register_store.sv
// top level of the versioned register store
`timescale 1ns / 1ps
// Usage: a versioned array of signed 32-bit elements.
// request channel carries op (0 set, 1 snap, 2 get), index, value and snap_id;
// response channel returns read_value, snap_number and status for every item.
// Set appends (current snapshot, value) to the element's history, or answers
// status 1 when that history is full. Snap returns the current snapshot number
// and advances it, answering status 2 once the counter sits at its maximum.
// Get returns the last value recorded at or before snap_id, 0 when none.
// Sequence: set, snap and unused codes pass through the count, exec and done
// states, and response valid rises once done loads the result; get runs a
// binary search from exec, a search and a compare state per probe (at most 5
// probes with 16 records), then a fetch state when a record qualifies, then
// done. The search runs through the record ram, one registered read per probe.
// One item is in work at a time; request.ready is high only while idle, so a
// new request is taken in the cycle after the previous result is loaded.
// The response sits in an output register, so a new request is taken while
// an earlier response waits; a stalled receiver holds the next result back.
// Reset (rst, synchronous) empties every history and zeroes the snapshot
// counter at once; no request is taken while it is held.
module versioned_register_store (
  input logic      clk,
  input logic      rst,
  vrs_req_if.sink   request,
  vrs_rsp_if.source response
);
  import vrs_pkg::*;

  vrs_cmd_t  cmd;
  vrs_stat_t stat;

  // sequencing
  vrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(request.valid),
    .req_ready(request.ready),
    .rsp_valid(response.valid),
    .rsp_ready(response.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  vrs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op_in      (request.op),
    .index_in   (request.index),
    .value_in   (request.value),
    .snap_id_in (request.snap_id),
    .read_value (response.read_value),
    .snap_number(response.snap_number),
    .status     (response.status)
  );
endmodule
